[design/sorted_unique_key_table_top_assert.svh]
// Assertion macros shared by the sorted key table checkers.
`ifndef SORTED_UNIQUE_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_UNIQUE_KEY_TABLE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SUK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SUK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/suk_pkg.sv]
// Shared types and codes for the sorted key table.
package suk_pkg;

  localparam int KEY_FIELD_W = 32;
  localparam int INDEX_W     = 6;
  localparam int POS_W       = 7;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_ERASE  = 3'd1;
  localparam logic [2:0] MODE_LOWER  = 3'd2;
  localparam logic [2:0] MODE_UPPER  = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;
  localparam logic [2:0] MODE_CLEAR  = 3'd5;

  localparam logic [2:0] STATUS_OK    = 3'd0;
  localparam logic [2:0] STATUS_DUP   = 3'd1;
  localparam logic [2:0] STATUS_MISS  = 3'd2;
  localparam logic [2:0] STATUS_FULL  = 3'd3;
  localparam logic [2:0] STATUS_RANGE = 3'd4;

  typedef struct packed {
    logic [2:0]             mode;
    logic [KEY_FIELD_W-1:0] key;
    logic [INDEX_W-1:0]     index;
  } suk_in_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [POS_W-1:0]       position;
    logic                   found;
    logic [KEY_FIELD_W-1:0] entry_value;
    logic [POS_W-1:0]       entry_count;
  } suk_out_t;

  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_INSERT,
    SHIFT_ERASE
  } shift_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    shift_e op;
    logic   order_desc;
  } suk_cell_ctrl_t;

  // Per-cell compare results returned to the controller.
  typedef struct packed {
    logic occupied;
    logic lt;
    logic le;
    logic eq;
  } suk_cell_flags_t;

endpackage

[design/suk_cell.sv]
// One slot of the sorted key row: compare against the search key and shift.
module suk_cell import suk_pkg::*; #(
  parameter int KEY_W = 32,
  parameter int CNT_W = 7,
  parameter int SLOT  = 0
) (
  input  logic            clk_i,
  input  suk_cell_ctrl_t  ctrl_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic            left_lt_i,
  input  logic [KEY_W-1:0] right_key_i,
  output logic [KEY_W-1:0] key_o,
  output suk_cell_flags_t flags_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic             occupied, ahead, eq, lt;

  assign occupied = CNT_W'(SLOT) < count_i;
  assign ahead    = ctrl_i.order_desc ? (key_q > key_i) : (key_q < key_i);
  assign eq       = key_q == key_i;
  assign lt       = occupied & ahead;

  assign flags_o.occupied = occupied;
  assign flags_o.lt       = lt;
  assign flags_o.le       = occupied & (ahead | eq);
  assign flags_o.eq       = eq;
  assign key_o            = key_q;

  // Slots at or past the boundary move right on insert, left on erase.
  always_comb begin
    key_d = key_q;
    unique case (ctrl_i.op)
      SHIFT_INSERT: begin
        if (!lt) key_d = left_lt_i ? key_i : left_key_i;
      end
      SHIFT_ERASE: begin
        if (!lt) key_d = right_key_i;
      end
      default: key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

[design/sorted_unique_key_table_top.sv]
// Top level of the sorted key table: cell row, result reduction, output register.
//
// Sorted table of up to CAPACITY distinct keys, held in a row of cells, one
// key per cell, largest first while order_descending is 1 and smallest first
// while it is 0. Every transfer on the input channel carries one operation
// (insert, erase, lower bound, upper bound, read at index, clear) and yields
// exactly one transfer on the output channel. For each operation every
// cell compares its key with the search key in parallel, the boundary
// of the sorted prefix gives the position, and on insert or erase all
// cells past that boundary shift by one slot in the same edge. The result
// sits in an output register in the cycle after the input transfer; a new item
// is taken in every cycle in which that register is empty or being drained,
// so the sustained rate is one item per clock. The width of the position and
// value reductions across the row (CAPACITY cells) sets the cycle time.
// Writing order_descending with a value different from the current one
// empties the table; writing the same value does nothing. Only the low
// KEY_WIDTH bits of a key are kept (at most 32). No clearing pass is needed
// after reset: the entry count alone marks which cells hold keys.
module sorted_unique_key_table_top import suk_pkg::*; #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  suk_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output suk_out_t out_data_o,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i
);

  localparam int KEY_W = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int RD_SLOTS = (CAPACITY < (1 << INDEX_W)) ? CAPACITY : (1 << INDEX_W);

  // Control and configuration state
  logic             order_desc_q;
  logic [CNT_W-1:0] count_q, count_d, count_item;
  logic             out_valid_q;
  suk_out_t         out_q, out_d;
  logic             in_accept;

  // Cell row
  logic [KEY_W-1:0] key_in;
  logic [KEY_W-1:0] cell_key   [CAPACITY];
  suk_cell_flags_t  cell_flags [CAPACITY];
  suk_cell_ctrl_t   cell_ctrl;
  logic [CAPACITY-1:0] lt_vec, le_vec, eq_vec, occ_vec;

  // Reductions across the row
  logic [CAPACITY:0] bnd_lo, bnd_up;
  logic [CNT_W-1:0]  pos_lo, pos_up;
  logic [KEY_W-1:0]  val_lo, val_up, val_rd;
  logic              hit_lo, hit_up, hit_rd, rd_ok, full;

  // Result fields
  logic [2:0]       status_d;
  logic [CNT_W-1:0] pos_d;
  logic             found_d;
  logic [KEY_W-1:0] val_d;

  assign key_in      = in_data_i.key[KEY_W-1:0];
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_W-1:0] left_key, right_key;
    logic             left_lt;

    // The first cell sees an open boundary on its left.
    if (g == 0) begin : g_first
      assign left_key = '0;
      assign left_lt  = 1'b1;
    end else begin : g_inner
      assign left_key = cell_key[g-1];
      assign left_lt  = lt_vec[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_body
      assign right_key = cell_key[g+1];
    end

    suk_cell #(
      .KEY_W (KEY_W),
      .CNT_W (CNT_W),
      .SLOT  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .count_i     (count_q),
      .key_i       (key_in),
      .left_key_i  (left_key),
      .left_lt_i   (left_lt),
      .right_key_i (right_key),
      .key_o       (cell_key[g]),
      .flags_o     (cell_flags[g])
    );

    assign lt_vec[g]  = cell_flags[g].lt;
    assign le_vec[g]  = cell_flags[g].le;
    assign eq_vec[g]  = cell_flags[g].eq;
    assign occ_vec[g] = cell_flags[g].occupied;
  end

  // The lt and le flags form prefixes of the row; each boundary is one-hot
  // over CAPACITY+1 places, the last one standing for "past the end".
  assign bnd_lo = {lt_vec, 1'b1} & ~{1'b0, lt_vec};
  assign bnd_up = {le_vec, 1'b1} & ~{1'b0, le_vec};

  // OR-reduce the one-hot boundaries into position, entry and match.
  always_comb begin
    pos_lo = '0;
    pos_up = '0;
    val_lo = '0;
    val_up = '0;
    hit_lo = 1'b0;
    hit_up = 1'b0;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (bnd_lo[i]) pos_lo = pos_lo | CNT_W'(i);
      if (bnd_up[i]) pos_up = pos_up | CNT_W'(i);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd_lo[i] && occ_vec[i]) val_lo = val_lo | cell_key[i];
      if (bnd_up[i] && occ_vec[i]) val_up = val_up | cell_key[i];
      hit_lo = hit_lo | (bnd_lo[i] & occ_vec[i] & eq_vec[i]);
      hit_up = hit_up | (bnd_up[i] & occ_vec[i] & eq_vec[i]);
    end
  end

  // Read at index: the index field reaches only the first slots of the row.
  always_comb begin
    val_rd = '0;
    for (int i = 0; i < RD_SLOTS; i++) begin
      if (CMP_W'(in_data_i.index) == CMP_W'(i)) val_rd = val_rd | cell_key[i];
    end
  end

  assign rd_ok  = CMP_W'(in_data_i.index) < CMP_W'(count_q);
  assign hit_rd = rd_ok && (val_rd == key_in);
  assign full   = count_q == CNT_W'(CAPACITY);

  // Decode the operation: drive the row's shift command and the result.
  always_comb begin
    cell_ctrl.op         = SHIFT_HOLD;
    cell_ctrl.order_desc = order_desc_q;
    count_item           = count_q;
    status_d             = STATUS_OK;
    pos_d                = count_q;
    found_d              = 1'b0;
    val_d                = '0;
    if (in_accept) begin
      unique case (in_data_i.mode)
        MODE_INSERT: begin
          pos_d = pos_lo;
          if (hit_lo) begin
            status_d = STATUS_DUP;
            found_d  = 1'b1;
            val_d    = key_in;
          end else if (full) begin
            status_d = STATUS_FULL;
            val_d    = val_lo;
          end else begin
            cell_ctrl.op = SHIFT_INSERT;
            count_item   = count_q + CNT_W'(1);
            found_d      = 1'b1;
            val_d        = key_in;
          end
        end
        MODE_ERASE: begin
          pos_d = pos_lo;
          if (hit_lo) begin
            cell_ctrl.op = SHIFT_ERASE;
            count_item   = count_q - CNT_W'(1);
            found_d      = 1'b1;
            val_d        = key_in;
          end else begin
            status_d = STATUS_MISS;
            val_d    = val_lo;
          end
        end
        MODE_LOWER: begin
          pos_d   = pos_lo;
          val_d   = val_lo;
          found_d = hit_lo;
        end
        MODE_UPPER: begin
          pos_d   = pos_up;
          val_d   = val_up;
          found_d = hit_up;
        end
        MODE_READ: begin
          if (rd_ok) begin
            pos_d   = CNT_W'(in_data_i.index);
            val_d   = val_rd;
            found_d = hit_rd;
          end else begin
            status_d = STATUS_RANGE;
          end
        end
        MODE_CLEAR: begin
          count_item = '0;
          pos_d      = '0;
        end
        default: pos_d = count_q;
      endcase
    end
  end

  assign out_d.status      = status_d;
  assign out_d.position    = POS_W'(pos_d);
  assign out_d.found       = found_d;
  assign out_d.entry_value = KEY_FIELD_W'(val_d);
  assign out_d.entry_count = POS_W'(count_item);

  // A change of sort order drops every held key.
  always_comb begin
    count_d = count_item;
    if (cfg_we_i && (cfg_wdata_i != order_desc_q)) count_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_desc_q <= 1'b1;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) order_desc_q <= cfg_wdata_i;
      count_q <= count_d;
      // Hold the result until the output transfer, then drop it.
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) out_q <= out_d;
  end

endmodule

[design/suk_checker.sv]
// Port-level checks for the sorted key table, bound to its top level.
`include "sorted_unique_key_table_top_assert.svh"

module suk_checker import suk_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input suk_out_t out_data_i
);

  // Every input transfer shows its result on the next cycle.
  `SUK_ASSERT_NEXT(a_result_follows, in_valid_i && in_ready_i, out_valid_i, "result missing after input transfer")

  // A stalled result blocks the input side.
  `SUK_ASSERT_SAME(a_stall_blocks_input, out_valid_i && !out_ready_i, !in_ready_i, "input ready while result stalled")

  // A stalled result holds its payload.
  `SUK_ASSERT_NEXT(a_result_holds, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result changed")

  // Table full is only reported at capacity.
  `SUK_ASSERT_SAME(a_full_at_capacity, out_valid_i && (out_data_i.status == STATUS_FULL), out_data_i.entry_count == 7'(CAPACITY), "full status below capacity")

endmodule

bind sorted_unique_key_table_top suk_checker #(
  .CAPACITY (CAPACITY)
) u_suk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

[sim/tb_sorted_unique_key_table_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the sorted key table: directed table, random phases, predictor.
module tb_sorted_unique_key_table_top;
  import suk_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int STALL_LIMIT = 1000;  // cycles with no transfer before giving up
  localparam int PHASES      = 8;

  // Modes 6 and 7 have no package name; the block treats them as no-ops.
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  typedef enum {STYLE_FILL, STYLE_MIX, STYLE_DRAIN} mix_style_e;

  // One operation to send, with an optional hand-written result that
  // replaces the predicted one.
  typedef struct {
    suk_in_t  item;
    bit       pinned;
    suk_out_t value;
  } plan_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  suk_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  suk_out_t out_data_o;
  logic     cfg_we_i    = 1'b0;
  logic     cfg_wdata_i = 1'b1;

  // Mirror of the table contents and the order register.
  logic [KEY_WIDTH-1:0] table_keys [CAPACITY];
  int                   table_count  = 0;
  bit                   order_desc_q = 1'b1;

  plan_row_t directed_plan [$];
  plan_row_t pending_ops [$];       // sent, waiting for the input transfer
  suk_out_t  expected_results [$];  // accepted, waiting for the output transfer
  int        errors = 0;
  bit        steady = 1'b0;         // no idling on either side while set

  sorted_unique_key_table_top #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------------

  // True when stored key a sits strictly ahead of key b in the current order.
  function automatic bit comes_first(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
    return order_desc_q ? (a > b) : (a < b);
  endfunction

  // Number of held keys ahead of k; with upper set, equal keys count too.
  function automatic int rank_of(logic [KEY_WIDTH-1:0] k, bit upper);
    int n;
    n = 0;
    for (int i = 0; i < table_count; i++)
      if (comes_first(table_keys[i], k) || (upper && table_keys[i] == k)) n++;
    return n;
  endfunction

  function automatic logic [KEY_WIDTH-1:0] entry_at(int p);
    return (p < table_count) ? table_keys[p] : '0;
  endfunction

  // Apply one operation to the mirror and return the result it yields.
  function automatic suk_out_t table_apply(suk_in_t item);
    suk_out_t r;
    int       p;
    int       i;
    r = '0;
    p = 0;
    case (item.mode)
      MODE_INSERT: begin
        p = rank_of(item.key, 1'b0);
        if (p < table_count && table_keys[p] == item.key) begin
          r.status      = STATUS_DUP;
          r.found       = 1'b1;
          r.entry_value = item.key;
        end else if (table_count >= CAPACITY) begin
          r.status      = STATUS_FULL;
          r.entry_value = entry_at(p);
        end else begin
          for (i = table_count; i > p; i--) table_keys[i] = table_keys[i-1];
          table_keys[p] = item.key;
          table_count++;
          r.found       = 1'b1;
          r.entry_value = item.key;
        end
      end
      MODE_ERASE: begin
        p = rank_of(item.key, 1'b0);
        if (p < table_count && table_keys[p] == item.key) begin
          r.found       = 1'b1;
          r.entry_value = item.key;
          for (i = p; i + 1 < table_count; i++) table_keys[i] = table_keys[i+1];
          table_count--;
        end else begin
          r.status      = STATUS_MISS;
          r.entry_value = entry_at(p);
        end
      end
      MODE_LOWER, MODE_UPPER: begin
        p             = rank_of(item.key, item.mode == MODE_UPPER);
        r.entry_value = entry_at(p);
        r.found       = (p < table_count) && (r.entry_value == item.key);
      end
      MODE_READ: begin
        if (int'(item.index) < table_count) begin
          p             = int'(item.index);
          r.entry_value = table_keys[p];
          r.found       = (r.entry_value == item.key);
        end else begin
          r.status = STATUS_RANGE;
          p        = table_count;
        end
      end
      MODE_CLEAR: table_count = 0;
      default: p = table_count;
    endcase
    r.position    = p[POS_W-1:0];
    r.entry_count = table_count[POS_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void plan_add(logic [2:0] mode, logic [KEY_WIDTH-1:0] key,
                                   logic [INDEX_W-1:0] index, bit pinned,
                                   logic [2:0] status = STATUS_OK, int pos = 0,
                                   bit found = 1'b0, logic [KEY_WIDTH-1:0] value = '0,
                                   int count = 0);
    plan_row_t row;
    row.item              = '{mode: mode, key: key, index: index};
    row.pinned            = pinned;
    row.value             = '0;
    row.value.status      = status;
    row.value.position    = pos[POS_W-1:0];
    row.value.found       = found;
    row.value.entry_value = value;
    row.value.entry_count = count[POS_W-1:0];
    directed_plan = {directed_plan, row};
  endfunction

  // Draw a random operation. The mode mix depends on the style so that the
  // table is driven to full, churned, and emptied again.
  function automatic suk_in_t random_op(mix_style_e style);
    suk_in_t item;
    int      roll;
    int      near_cut;
    int      cut_ins, cut_era, cut_low, cut_up, cut_read, cut_clr;
    case (style)
      STYLE_FILL: begin
        cut_ins = 65; cut_era = 70; cut_low = 78; cut_up = 86; cut_read = 97; cut_clr = 97;
      end
      STYLE_MIX: begin
        cut_ins = 30; cut_era = 55; cut_low = 67; cut_up = 79; cut_read = 94; cut_clr = 96;
      end
      default: begin
        cut_ins = 10; cut_era = 70; cut_low = 77; cut_up = 84; cut_read = 95; cut_clr = 96;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < cut_ins)       item.mode = MODE_INSERT;
    else if (roll < cut_era)  item.mode = MODE_ERASE;
    else if (roll < cut_low)  item.mode = MODE_LOWER;
    else if (roll < cut_up)   item.mode = MODE_UPPER;
    else if (roll < cut_read) item.mode = MODE_READ;
    else if (roll < cut_clr)  item.mode = MODE_CLEAR;
    else item.mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;

    // Favor keys already held (hits, duplicates) and their neighbors
    // (near misses); keep fresh keys dominant while filling.
    near_cut = (style == STYLE_FILL) ? 10 : 35;
    roll     = $urandom_range(0, 99);
    if (table_count > 0 && roll < near_cut)
      item.key = table_keys[$urandom_range(0, table_count - 1)];
    else if (table_count > 0 && roll < near_cut + 15)
      item.key = table_keys[$urandom_range(0, table_count - 1)] +
                 ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
    else if (roll < 65)
      item.key = $urandom_range(0, 31);
    else if (roll < 72)
      case ($urandom_range(0, 3))
        0:       item.key = 32'h0000_0000;
        1:       item.key = 32'hFFFF_FFFF;
        2:       item.key = 32'h7FFF_FFFF;
        default: item.key = 32'h8000_0000;
      endcase
    else
      item.key = $urandom();

    if ($urandom_range(0, 1))
      item.index = INDEX_W'($urandom_range(0, (table_count < 63) ? table_count : 63));
    else
      item.index = INDEX_W'($urandom_range(0, 63));
    return item;
  endfunction

  // Present one operation and hold it until the input transfer. Starts and
  // ends at a falling edge; valid is lowered only when a gap is taken.
  task automatic send_op(plan_row_t row);
    while (!steady && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    pending_ops = {pending_ops, row};
    in_valid_i <= 1'b1;
    in_data_i  <= row.item;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid and hold the sender until every expected result has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0 || pending_ops.size() != 0) @(negedge clk_i);
  endtask

  // Write the order register while idle; a changed value empties the table.
  task automatic write_order(bit descending);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= descending;
    @(posedge clk_i);
    if (descending != order_desc_q) table_count = 0;
    order_desc_q = descending;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, off during the steady stretch
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_ready_i <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input transfer, compare on each output transfer.
  // The push comes first so a same-edge result would still find its entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    plan_row_t row;
    suk_out_t  predicted;
    suk_out_t  want;
    if (in_valid_i && in_ready_o) begin
      row       = pending_ops[0];
      pending_ops.delete(0);
      predicted = table_apply(in_data_i);
      expected_results = {expected_results, (row.pinned ? row.value : predicted)};
    end
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        errors++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_data_o.position);
          errors++;
        end
        if (out_data_o.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_data_o.found);
          errors++;
        end
        if (out_data_o.entry_value !== want.entry_value) begin
          $error("entry_value: expected %08h, got %08h",
                 want.entry_value, out_data_o.entry_value);
          errors++;
        end
        if (out_data_o.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 want.entry_count, out_data_o.entry_count);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: stop when neither channel nor the register port moves for long
  // ---------------------------------------------------------------------------
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i || !rst_ni)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL sorted_unique_key_table_top");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit         phase_order [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    mix_style_e phase_style [PHASES] = '{STYLE_FILL, STYLE_MIX, STYLE_DRAIN, STYLE_FILL,
                                         STYLE_MIX, STYLE_FILL, STYLE_DRAIN, STYLE_MIX};
    int         phase_items [PHASES] = '{150, 110, 110, 150, 110, 150, 110, 110};
    plan_row_t  row;

    // Directed rows, descending order after reset. Hand-written results
    // cover the empty table, the key extremes, duplicates, out-of-range
    // reads, the spare modes and clear; the rest go to the predictor.
    plan_add(MODE_READ,   32'h0,         6'd0,  1'b1, STATUS_RANGE, 0, 0, 32'h0, 0);
    plan_add(MODE_ERASE,  32'h5,         6'd0,  1'b1, STATUS_MISS,  0, 0, 32'h0, 0);
    plan_add(MODE_LOWER,  32'h0,         6'd0,  1'b1, STATUS_OK,    0, 0, 32'h0, 0);
    plan_add(MODE_INSERT, 32'hFFFF_FFFF, 6'd0,  1'b1, STATUS_OK,    0, 1, 32'hFFFF_FFFF, 1);
    plan_add(MODE_INSERT, 32'h0,         6'd0,  1'b1, STATUS_OK,    1, 1, 32'h0, 2);
    plan_add(MODE_INSERT, 32'hFFFF_FFFF, 6'd0,  1'b1, STATUS_DUP,   0, 1, 32'hFFFF_FFFF, 2);
    plan_add(MODE_INSERT, 32'h8000_0000, 6'd0,  1'b0);
    plan_add(MODE_LOWER,  32'h8000_0000, 6'd0,  1'b0);
    plan_add(MODE_UPPER,  32'h8000_0000, 6'd0,  1'b0);
    plan_add(MODE_UPPER,  32'hFFFF_FFFF, 6'd0,  1'b0);
    plan_add(MODE_LOWER,  32'h1234_5678, 6'd0,  1'b0);
    plan_add(MODE_READ,   32'h0,         6'd2,  1'b0);
    plan_add(MODE_READ,   32'hFFFF_FFFF, 6'd63, 1'b1, STATUS_RANGE, 3, 0, 32'h0, 3);
    plan_add(MODE_SPARE_A, 32'h7,        6'd21, 1'b1, STATUS_OK,    3, 0, 32'h0, 3);
    plan_add(MODE_SPARE_B, 32'hFFFF_FFFF, 6'd42, 1'b1, STATUS_OK,   3, 0, 32'h0, 3);
    plan_add(MODE_ERASE,  32'h8000_0000, 6'd0,  1'b0);
    plan_add(MODE_ERASE,  32'h8000_0001, 6'd0,  1'b0);
    plan_add(MODE_UPPER,  32'h0,         6'd0,  1'b0);
    plan_add(MODE_CLEAR,  32'hFFFF_FFFF, 6'd63, 1'b1, STATUS_OK,    0, 0, 32'h0, 0);
    plan_add(MODE_ERASE,  32'h0,         6'd0,  1'b1, STATUS_MISS,  0, 0, 32'h0, 0);

    // Hold reset, then release it at a falling edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_plan[i]) send_op(directed_plan[i]);

    // Random phases. Each one starts from an idle block with a register
    // write, so the order flips several times and also gets rewritten with
    // its current value. Phase 3 runs with no idling on either side.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      steady = (ph == 3);
      write_order(phase_order[ph]);
      for (int n = 0; n < phase_items[ph]; n++) begin
        row.item   = random_op(phase_style[ph]);
        row.pinned = 1'b0;
        row.value  = '0;
        send_op(row);
      end
    end

    wait_drained();
    steady = 1'b0;
    repeat (4) @(posedge clk_i);

    if (errors == 0) begin
      $display("PASS sorted_unique_key_table_top");
    end else begin
      $display("FAIL sorted_unique_key_table_top");
    end
    $finish;
  end

endmodule
